// ===== src/line_sensor_color_debounce_assert.svh =====
// ----------------------------------------------------------------------------
// Line sensor color debounce: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LINE_SENSOR_COLOR_DEBOUNCE_ASSERT_SVH
`define LINE_SENSOR_COLOR_DEBOUNCE_ASSERT_SVH

// An implication that is checked only outside of reset.
`define LSCD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("line_sensor_color_debounce: check failed");

// A condition that must hold on the first edge after reset is released.
`define LSCD_ASSERT_AFTER_RESET(label, cons) \
    label: assert property (@(posedge i_clk) (i_rst_n && $past(!i_rst_n)) |-> (cons)) \
        else $error("line_sensor_color_debounce: state after reset is wrong");

`endif

// ===== src/lscd_pkg.sv =====
// ----------------------------------------------------------------------------
// Line sensor colour debounce: package
// Widths, colour codes, register indexes, reset values and the zone
// classification functions shared by the block's modules.
// ----------------------------------------------------------------------------
package lscd_pkg;

    localparam int SENSOR_W     = 16;
    localparam int COLOUR_W     = 3;
    localparam int SETTLE_W     = 8;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int WINDOW_COUNT = 4;
    localparam int QUEUE_DEPTH  = 2;

    typedef logic [COLOUR_W-1:0] t_colour;
    typedef logic [SENSOR_W-1:0] t_level;
    typedef logic [SETTLE_W-1:0] t_count;

    // Colour codes.
    localparam t_colour COLOUR_BLACK   = 3'd0;
    localparam t_colour COLOUR_GREY    = 3'd1;
    localparam t_colour COLOUR_GREEN   = 3'd2;
    localparam t_colour COLOUR_BROWN   = 3'd3;
    localparam t_colour COLOUR_UNKNOWN = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_BLACK = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_GREY  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_GREEN = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_BROWN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_COUNT = 3'd4;

    // A colour window: maximum in the upper half, minimum in the lower half.
    typedef struct packed {
        t_level hi;
        t_level lo;
    } t_window;

    typedef t_window [WINDOW_COUNT-1:0] t_window_set;

    // Reset values. The grey window is empty on purpose (minimum above maximum).
    localparam t_window WINDOW_BLACK_RST = '{hi: 16'd910, lo: 16'd750};
    localparam t_window WINDOW_GREY_RST  = '{hi: 16'd990, lo: 16'd995};
    localparam t_window WINDOW_GREEN_RST = '{hi: 16'd430, lo: 16'd130};
    localparam t_window WINDOW_BROWN_RST = '{hi: 16'd120, lo: 16'd70};
    localparam t_count  SETTLE_RST       = 8'd8;
    localparam t_count  COUNT_MAX        = 8'd255;

    // Classified zones of one frame, as held in the queue.
    typedef struct packed {
        t_colour left;
        t_colour middle;
        t_colour right;
    } t_zone;

    // Queue fill status as seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Floor of the mean of two readings.
    function automatic t_level zone_average(input t_level a, input t_level b);
        logic [SENSOR_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[SENSOR_W:1];
    endfunction

    // The lowest numbered window that holds the level wins; none gives unknown.
    function automatic t_colour classify(input t_level level, input t_window_set windows);
        t_colour colour;
        colour = COLOUR_UNKNOWN;
        for (int k = WINDOW_COUNT - 1; k >= 0; k--) begin
            if (level >= windows[k].lo && level <= windows[k].hi) begin
                colour = t_colour'(k);
            end
        end
        return colour;
    endfunction

endpackage

// ===== src/lscd_front.sv =====
// ----------------------------------------------------------------------------
// Line sensor colour debounce: front part
// Accepts sensor frames, forms the three zone levels and classifies each
// against the colour windows, then pushes the result into the queue.
// ----------------------------------------------------------------------------
module lscd_front (
    input  logic                 i_in_valid,
    input  lscd_pkg::t_level     i_sensor_a,
    input  lscd_pkg::t_level     i_sensor_b,
    input  lscd_pkg::t_level     i_sensor_c,
    input  lscd_pkg::t_level     i_sensor_d,
    input  lscd_pkg::t_level     i_sensor_e,
    input  lscd_pkg::t_window_set i_windows,
    input  lscd_pkg::t_q_status  i_status,
    output logic                 o_in_stall,
    output logic                 o_push,
    output lscd_pkg::t_zone      o_push_data
);
    import lscd_pkg::*;

    t_level left_level;
    t_level right_level;

    // A frame is taken whenever the queue has room.
    assign o_in_stall = i_status.full;
    assign o_push     = i_in_valid && !i_status.full;

    // Zone levels: outer pairs are averaged, the middle sensor stands alone.
    assign left_level  = zone_average(i_sensor_a, i_sensor_b);
    assign right_level = zone_average(i_sensor_d, i_sensor_e);

    // Window classification of all three zones.
    always_comb begin
        o_push_data.left   = classify(left_level, i_windows);
        o_push_data.middle = classify(i_sensor_c, i_windows);
        o_push_data.right  = classify(right_level, i_windows);
    end

endmodule

// ===== src/lscd_queue.sv =====
// ----------------------------------------------------------------------------
// Line sensor colour debounce: decoupling queue
// A small circular buffer of classified frames between the front and back
// parts, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module lscd_queue #(
    parameter int DEPTH = lscd_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lscd_pkg::t_zone     i_push_data,
    input  logic                i_pop,
    output lscd_pkg::t_zone     o_head,
    output lscd_pkg::t_q_status o_status
);
    import lscd_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_zone            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);

    // Pointer and fill count updates; push and pop may happen together.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== src/lscd_back.sv =====
// ----------------------------------------------------------------------------
// Line sensor colour debounce: back part
// Takes classified frames from the queue in order, runs the repeat-count
// debounce on the middle colour and holds the result for the output side.
// ----------------------------------------------------------------------------
module lscd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lscd_pkg::t_q_status i_status,
    input  lscd_pkg::t_zone     i_head,
    input  lscd_pkg::t_count    i_settle_count,
    input  logic                i_out_stall,
    output logic                o_pop,
    output logic                o_out_valid,
    output lscd_pkg::t_colour   o_left_colour,
    output lscd_pkg::t_colour   o_middle_colour,
    output lscd_pkg::t_colour   o_right_colour,
    output lscd_pkg::t_colour   o_settled_colour
);
    import lscd_pkg::*;

    logic    r_out_valid, n_out_valid;
    t_zone   r_out;
    t_colour r_stable, n_stable;
    t_colour r_candidate, n_candidate;
    t_count  r_count, n_count;
    t_count  count_inc;

    // The output register is free when empty or when its transfer happens now.
    assign o_pop = !i_status.empty && (!r_out_valid || !i_out_stall);

    // Saturating repeat count.
    assign count_inc = (r_count == COUNT_MAX) ? COUNT_MAX : r_count + 1'b1;

    // Debounce update for the frame taken from the queue.
    always_comb begin
        n_stable    = r_stable;
        n_candidate = r_candidate;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        if (o_pop) begin
            n_out_valid = 1'b1;
            if (i_head.middle == r_candidate) begin
                n_count = count_inc;
                if (count_inc >= i_settle_count) begin
                    n_stable = i_head.middle;
                end
            end else begin
                n_candidate = i_head.middle;
                n_count     = t_count'(1);
            end
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_stable    <= COLOUR_UNKNOWN;
            r_candidate <= COLOUR_UNKNOWN;
            r_count     <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_stable    <= n_stable;
            r_candidate <= n_candidate;
            r_count     <= n_count;
        end
    end

    // Zone colours of the held result.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= i_head;
        end
    end

    // The stable colour changes only together with a new result.
    assign o_out_valid      = r_out_valid;
    assign o_left_colour    = r_out.left;
    assign o_middle_colour  = r_out.middle;
    assign o_right_colour   = r_out.right;
    assign o_settled_colour = r_stable;

endmodule

// ===== src/line_sensor_color_debounce.sv =====
// ----------------------------------------------------------------------------
// Line sensor color debounce: top level
// Classifies the left, middle and right zones of a five-sensor frame into
// colors and debounces the middle color.
// ----------------------------------------------------------------------------
// The block takes one sensor frame per clock cycle while the queue has room,
// and returns one result per frame, in order. The front part classifies each
// transferred frame into a queue of QUEUE_DEPTH entries, and the back part
// moves it from the queue through the debounce into the output register. The
// output register and the queue together let the input keep transferring
// while a result is stalled; the input stalls only once the queue is full, so
// up to QUEUE_DEPTH + 1 frames can be held. The user must write the color
// windows and the settle count through the configuration port only while no
// frame is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "line_sensor_color_debounce_assert.svh"

module line_sensor_color_debounce #(
    parameter int QUEUE_DEPTH = lscd_pkg::QUEUE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [lscd_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [lscd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  lscd_pkg::t_level                     i_sensor_a,
    input  lscd_pkg::t_level                     i_sensor_b,
    input  lscd_pkg::t_level                     i_sensor_c,
    input  lscd_pkg::t_level                     i_sensor_d,
    input  lscd_pkg::t_level                     i_sensor_e,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output lscd_pkg::t_colour                    o_left_colour,
    output lscd_pkg::t_colour                    o_middle_colour,
    output lscd_pkg::t_colour                    o_right_colour,
    output lscd_pkg::t_colour                    o_settled_colour
);
    import lscd_pkg::*;

    t_window_set r_windows;
    t_count      r_settle;
    logic        push;
    logic        pop;
    t_zone       push_data;
    t_zone       head;
    t_q_status   q_status;
    logic        out_xfer;
    logic        colours_legal;
    logic        settled_on_mid;

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_windows[0] <= WINDOW_BLACK_RST;
            r_windows[1] <= WINDOW_GREY_RST;
            r_windows[2] <= WINDOW_GREEN_RST;
            r_windows[3] <= WINDOW_BROWN_RST;
            r_settle     <= SETTLE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WINDOW_BLACK: r_windows[0] <= i_cfg_data;
                CFG_WINDOW_GREY:  r_windows[1] <= i_cfg_data;
                CFG_WINDOW_GREEN: r_windows[2] <= i_cfg_data;
                CFG_WINDOW_BROWN: r_windows[3] <= i_cfg_data;
                CFG_SETTLE_COUNT: r_settle     <= i_cfg_data[SETTLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Front part: frame transfer and zone classification.
    lscd_front u_front (
        .i_in_valid  (i_in_valid),
        .i_sensor_a  (i_sensor_a),
        .i_sensor_b  (i_sensor_b),
        .i_sensor_c  (i_sensor_c),
        .i_sensor_d  (i_sensor_d),
        .i_sensor_e  (i_sensor_e),
        .i_windows   (r_windows),
        .i_status    (q_status),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // Queue between the two parts.
    lscd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    // Back part: debounce and output register.
    lscd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_status         (q_status),
        .i_head           (head),
        .i_settle_count   (r_settle),
        .i_out_stall      (i_out_stall),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .o_left_colour    (o_left_colour),
        .o_middle_colour  (o_middle_colour),
        .o_right_colour   (o_right_colour),
        .o_settled_colour (o_settled_colour)
    );

    // Terms used by the checks below.
    assign out_xfer       = o_out_valid && !i_out_stall;
    assign colours_legal  = (o_left_colour <= COLOUR_UNKNOWN) &&
                            (o_middle_colour <= COLOUR_UNKNOWN) &&
                            (o_right_colour <= COLOUR_UNKNOWN) &&
                            (o_settled_colour <= COLOUR_UNKNOWN);
    assign settled_on_mid = (o_settled_colour == o_middle_colour);

    // Both channels come out of reset empty and ready.
    `LSCD_ASSERT_AFTER_RESET(a_reset_idle, !o_out_valid && !o_in_stall)
    // Delivered colors are always legal codes.
    `LSCD_ASSERT_IMPL(a_colour_legal, o_out_valid, colours_legal)
    // Between back-to-back results the settled color only moves to the middle color.
    `LSCD_ASSERT_IMPL(a_settle, out_xfer ##1 out_xfer, $stable(o_settled_colour) || settled_on_mid)

endmodule

// ===== tb/line_sensor_color_debounce_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line sensor color debounce: testbench
// Drives sensor frames through the block under random idling and
// back-pressure. The expected zone and settled colors of each frame are
// computed by a local copy of the classification and debounce, and each
// result transfer is checked against them in order.
// ----------------------------------------------------------------------------
module line_sensor_color_debounce_test;
    import lscd_pkg::*;

    localparam int CLK_HIGH      = 6;
    localparam int CLK_LOW       = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int IDLE_PERCENT  = 9;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int FLUSH_CYCLES  = 4;
    localparam int HOLD_CYCLES   = 80;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 115;
    localparam int SATURATE_RUN  = 300;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_index;
    typedef logic [CFG_DATA_W-1:0]  t_cfg_data;

    localparam t_cfg_index CFG_INDEX_TOP = 3'd7;

    // Colors expected from one frame.
    typedef struct packed {
        t_colour left;
        t_colour middle;
        t_colour right;
        t_colour settled;
    } t_frame_colours;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    t_cfg_index i_cfg_index = '0;
    t_cfg_data  i_cfg_data  = '0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    t_level     i_sensor_a  = '0;
    t_level     i_sensor_b  = '0;
    t_level     i_sensor_c  = '0;
    t_level     i_sensor_d  = '0;
    t_level     i_sensor_e  = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_colour    o_left_colour;
    t_colour    o_middle_colour;
    t_colour    o_right_colour;
    t_colour    o_settled_colour;

    // Local copy of the color windows and the debounce state.
    t_window_set shadow_windows;
    t_count      shadow_settle;
    t_colour     shadow_stable;
    t_colour     shadow_candidate;
    t_count      shadow_repeats;

    t_frame_colours pending_colours[$];
    int mismatches    = 0;
    int cycle_count   = 0;
    bit steady_flow   = 1'b0;
    bit hold_request  = 1'b0;
    int hold_left     = 0;

    line_sensor_color_debounce DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sensor_a       (i_sensor_a),
        .i_sensor_b       (i_sensor_b),
        .i_sensor_c       (i_sensor_c),
        .i_sensor_d       (i_sensor_d),
        .i_sensor_e       (i_sensor_e),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_left_colour    (o_left_colour),
        .o_middle_colour  (o_middle_colour),
        .o_right_colour   (o_right_colour),
        .o_settled_colour (o_settled_colour)
    );

    always begin
        #CLK_HIGH i_clk = 1'b1;
        #CLK_LOW  i_clk = 1'b0;
    end

    // Give up if the run hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("line_sensor_color_debounce_test: FAIL");
            $finish;
        end
    end

    // The result side stalls at random, or for a long hold when one is requested.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left--;
        end else if (steady_flow) begin
            i_out_stall = 1'b0;
        end else begin
            i_out_stall = ($urandom_range(0, 99) < IDLE_PERCENT);
        end
    end

    // Compare every result transfer with the oldest expected frame.
    always @(posedge i_clk) begin
        t_frame_colours want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_colours.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: result transfer with no frame outstanding", $realtime);
                end
            end else begin
                want = pending_colours.pop_front();
                if (want.left != o_left_colour || want.middle != o_middle_colour ||
                        want.right != o_right_colour || want.settled != o_settled_colour) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: colors expected L%0d M%0d R%0d S%0d, got L%0d M%0d R%0d S%0d",
                                 $realtime, want.left, want.middle, want.right, want.settled,
                                 o_left_colour, o_middle_colour, o_right_colour,
                                 o_settled_colour);
                    end
                end
            end
        end
    end

    // The first window, in priority order, that holds the level names the color.
    function automatic t_colour lookup_colour(input t_level level);
        t_colour found;
        found = COLOUR_UNKNOWN;
        for (int k = 0; k < WINDOW_COUNT; k++) begin
            if (found == COLOUR_UNKNOWN && level >= shadow_windows[k].lo &&
                    level <= shadow_windows[k].hi) begin
                found = t_colour'(k);
            end
        end
        return found;
    endfunction

    // Classify one frame and advance the debounce state.
    function automatic t_frame_colours predict_colours(input t_level a, input t_level b,
                                                       input t_level c, input t_level d,
                                                       input t_level e);
        t_frame_colours p;
        p.left   = lookup_colour(t_level'((32'(a) + 32'(b)) >> 1));
        p.middle = lookup_colour(c);
        p.right  = lookup_colour(t_level'((32'(d) + 32'(e)) >> 1));
        if (p.middle == shadow_candidate) begin
            if (shadow_repeats != COUNT_MAX) begin
                shadow_repeats = shadow_repeats + 1'b1;
            end
            if (shadow_repeats >= shadow_settle) begin
                shadow_stable = p.middle;
            end
        end else begin
            shadow_candidate = p.middle;
            shadow_repeats = 8'd1;
        end
        p.settled = shadow_stable;
        return p;
    endfunction

    // A level aimed at the edges or inside of one of the current windows, or a random level.
    function automatic t_level pick_level();
        t_window w;
        w = shadow_windows[$urandom_range(0, WINDOW_COUNT - 1)];
        case ($urandom_range(0, 9))
            0, 1: return t_level'($urandom_range(0, 65535));
            2: return w.lo;
            3: return w.hi;
            4: return w.lo - 1'b1;
            5: return w.hi + 1'b1;
            default: return (w.lo <= w.hi) ? t_level'($urandom_range(w.lo, w.hi)) : w.lo;
        endcase
    endfunction

    // A random window: mostly narrow, sometimes empty, full or a single level.
    function automatic t_window make_window();
        t_window w;
        int lo;
        int span;
        case ($urandom_range(0, 7))
            0: begin
                w.lo = t_level'($urandom_range(1, 65535));
                w.hi = t_level'($urandom_range(0, w.lo - 1));
            end
            1: begin
                w.lo = '0;
                w.hi = '1;
            end
            2: begin
                w.lo = t_level'($urandom_range(0, 65535));
                w.hi = w.lo;
            end
            default: begin
                lo = $urandom_range(0, 65535);
                span = $urandom_range(0, 6000);
                w.lo = t_level'(lo);
                w.hi = (lo + span > 65535) ? 16'hFFFF : t_level'(lo + span);
            end
        endcase
        return w;
    endfunction

    // Write one register with no frame offered; the write takes effect at the rising edge while the enable is up.
    task automatic write_register(input t_cfg_index index, input t_cfg_data value);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        i_cfg_we = 1'b1;
        i_cfg_index = index;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (index < CFG_SETTLE_COUNT) begin
            shadow_windows[index] = value;
        end else if (index == CFG_SETTLE_COUNT) begin
            shadow_settle = value[SETTLE_W-1:0];
        end
    endtask

    // Offer one frame and hold it until the input transfer happens.
    task automatic send_frame(input t_level a, input t_level b, input t_level c,
                              input t_level d, input t_level e);
        @(negedge i_clk);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_sensor_a = a;
        i_sensor_b = b;
        i_sensor_c = c;
        i_sensor_d = d;
        i_sensor_e = e;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        pending_colours.push_back(predict_colours(a, b, c, d, e));
    endtask

    // Frame with a chosen middle level; outer pairs are often equal so the mean hits a window.
    task automatic send_with_middle(input t_level mid);
        t_level a;
        t_level b;
        t_level d;
        t_level e;
        a = pick_level();
        b = $urandom_range(0, 1) ? a : pick_level();
        d = pick_level();
        e = $urandom_range(0, 1) ? d : pick_level();
        send_frame(a, b, mid, d, e);
    endtask

    // Stop offering frames and wait until every expected result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_colours.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (FLUSH_CYCLES) @(posedge i_clk);
    endtask

    // Window edges, the empty grey window and the settle at reset values.
    task automatic test_reset_windows();
        send_frame(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_frame(16'd750, 16'd750, 16'd750, 16'd910, 16'd910);
        send_frame(16'd749, 16'd750, 16'd749, 16'd911, 16'd911);
        send_frame(16'd751, 16'd750, 16'd911, 16'd910, 16'd911);
        send_frame(16'd130, 16'd130, 16'd130, 16'd430, 16'd430);
        send_frame(16'd129, 16'd130, 16'd430, 16'd431, 16'd430);
        send_frame(16'd70, 16'd70, 16'd70, 16'd120, 16'd120);
        send_frame(16'd69, 16'd70, 16'd120, 16'd121, 16'd120);
        send_frame(16'd990, 16'd995, 16'd992, 16'd990, 16'd990);
        send_frame(16'd995, 16'd995, 16'd995, 16'hFFFF, 16'd1);
        send_frame(16'hFFFF, 16'hFFFE, 16'd121, 16'd0, 16'd1);
        // A run of black in the middle settles at the eighth repeat.
        repeat (9) send_with_middle(16'd800);
    endtask

    // Overlapping windows, a single-level window, a full-range window and zero settle.
    task automatic test_window_writes();
        drain_results();
        write_register(CFG_WINDOW_BLACK, t_window'{hi: 16'd200, lo: 16'd100});
        write_register(CFG_WINDOW_GREY, t_window'{hi: 16'd1000, lo: 16'd1000});
        write_register(CFG_WINDOW_GREEN, t_window'{hi: 16'd430, lo: 16'd130});
        write_register(CFG_WINDOW_BROWN, t_window'{hi: 16'hFFFF, lo: 16'd0});
        write_register(CFG_SETTLE_COUNT, 32'd0);
        send_frame(16'd150, 16'd150, 16'd150, 16'd150, 16'd150);
        send_frame(16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000);
        send_frame(16'd1000, 16'd1000, 16'd1000, 16'd1000, 16'd1000);
        send_frame(16'd999, 16'd1001, 16'd999, 16'd0, 16'hFFFF);
        send_frame(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_frame(16'd430, 16'd431, 16'd430, 16'd99, 16'd101);
    endtask

    // Upper bits of the settle write are dropped, and writes past the last register do nothing.
    task automatic test_register_masking();
        drain_results();
        write_register(CFG_SETTLE_COUNT, 32'hFFFF_FF03);
        for (int i = CFG_SETTLE_COUNT + 1; i <= CFG_INDEX_TOP; i++) begin
            write_register(t_cfg_index'(i), '1);
        end
        write_register(CFG_WINDOW_BLACK, 32'hFFFF_FFFF);
        send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE);
        repeat (4) send_with_middle(16'd300);
        send_with_middle(16'd1000);
    endtask

    // The repeat counter saturates during a long run; then a settle of one.
    task automatic test_settle_saturation();
        drain_results();
        write_register(CFG_SETTLE_COUNT, 32'd255);
        repeat (SATURATE_RUN) send_with_middle(16'd1000);
        send_with_middle(16'd150);
        drain_results();
        write_register(CFG_SETTLE_COUNT, 32'd1);
        send_with_middle(16'd150);
        send_with_middle(16'd150);
        send_with_middle(16'd1000);
        send_with_middle(16'd150);
        send_with_middle(16'd150);
        send_with_middle(16'd1000);
        send_with_middle(16'd1000);
    endtask

    // A long hold on results fills the block while frames keep coming.
    task automatic test_backpressure();
        drain_results();
        steady_flow = 1'b1;
        hold_request = 1'b1;
        repeat (24) send_with_middle(pick_level());
        drain_results();
        hold_request = 1'b1;
        repeat (12) send_with_middle(pick_level());
        drain_results();
        steady_flow = 1'b0;
    endtask

    // Random windows and settle counts per phase; middle levels come in runs.
    task automatic test_random_phases();
        int sent;
        int run;
        int settle_value;
        t_level mid;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            steady_flow = (phase == RANDOM_PHASES / 2);
            write_register(CFG_WINDOW_BLACK, make_window());
            write_register(CFG_WINDOW_GREY, make_window());
            write_register(CFG_WINDOW_GREEN, make_window());
            write_register(CFG_WINDOW_BROWN, make_window());
            if (phase == 0) begin
                settle_value = 0;
            end else if (phase == RANDOM_PHASES - 1) begin
                settle_value = 255;
            end else if ($urandom_range(0, 1)) begin
                settle_value = $urandom_range(1, 3);
            end else begin
                settle_value = $urandom_range(0, 20);
            end
            write_register(CFG_SETTLE_COUNT, ($urandom() & 32'hFFFF_FF00) | settle_value);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                mid = pick_level();
                run = (shadow_settle > 12) ? $urandom_range(1, 16)
                                           : $urandom_range(1, shadow_settle + 3);
                // Some runs are single frames of noise.
                if ($urandom_range(0, 4) == 0) begin
                    run = 1;
                end
                for (int r = 0; r < run && sent < PHASE_ITEMS; r++) begin
                    send_with_middle(mid);
                    sent++;
                end
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        shadow_windows[CFG_WINDOW_BLACK] = WINDOW_BLACK_RST;
        shadow_windows[CFG_WINDOW_GREY]  = WINDOW_GREY_RST;
        shadow_windows[CFG_WINDOW_GREEN] = WINDOW_GREEN_RST;
        shadow_windows[CFG_WINDOW_BROWN] = WINDOW_BROWN_RST;
        shadow_settle    = SETTLE_RST;
        shadow_stable    = COLOUR_UNKNOWN;
        shadow_candidate = COLOUR_UNKNOWN;
        shadow_repeats   = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_windows();
        test_window_writes();
        test_register_masking();
        test_settle_saturation();
        test_backpressure();
        test_random_phases();
        drain_results();

        if (mismatches == 0) begin
            $display("line_sensor_color_debounce_test: PASS");
        end else begin
            $display("line_sensor_color_debounce_test: FAIL");
        end
        $finish;
    end

endmodule
